### design/sldf_pkg.sv
// ----------------------------------------------------------------------------
// sldf_pkg
// Shared types and constants of the sync/length packet deframer.
// ----------------------------------------------------------------------------
package sldf_pkg;

	localparam logic [7:0]  SYNC_BYTE     = 8'h23;
	localparam int          HDR_LEN       = 7;
	localparam int          IDX_W         = 3;
	localparam logic [IDX_W-1:0] HDR_LAST_IDX = IDX_W'(HDR_LEN - 1);
	localparam int          LEN_W         = 12;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd2048;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       first_of_packet;
		logic       last_of_packet;
	} out_item_t;

	typedef logic [LEN_W-1:0] cfg_item_t;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_HDR,
		ST_EMIT,
		ST_BODY
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic store_byte;  // write input byte into header store at index
		logic inc_idx;
		logic clr_idx;
		logic load_body;   // body count = length - header length
		logic dec_body;
		logic emit_hdr;    // load header byte at index into output register
		logic emit_body;   // load input byte into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_sync;
		logic idx_last;
		logic hdr_ok;
		logic len_is_hdr;
		logic body_last;
		logic out_space;
	} stat_t;

endpackage

### design/sldf_chan_if.sv
// ----------------------------------------------------------------------------
// sldf_chan_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface sldf_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/sldf_dp.sv
// ----------------------------------------------------------------------------
// sldf_dp
// Datapath: header store, index and body counters, length register,
// header check and output register.
// ----------------------------------------------------------------------------
module sldf_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sldf_pkg::cmd_t       cmd,
	output sldf_pkg::stat_t      stat,
	input  logic [7:0]           in_byte,
	input  logic                 cfg_we,
	input  sldf_pkg::cfg_item_t  cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sldf_pkg::out_item_t  out_data
);
	import sldf_pkg::*;

	logic [7:0]       hdr_q [HDR_LEN];
	logic [IDX_W-1:0] idx_q;
	logic [LEN_W-1:0] max_len_q;
	logic [LEN_W-1:0] body_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic [15:0]      pkt_len;
	logic             sync_ok;

	assign pkt_len = {hdr_q[5], hdr_q[4]};
	assign sync_ok = (hdr_q[1] == SYNC_BYTE) && (hdr_q[2] == SYNC_BYTE) &&
	                 (hdr_q[3] == SYNC_BYTE);

	always_comb begin
		stat.is_sync    = (in_byte == SYNC_BYTE);
		stat.idx_last   = (idx_q == HDR_LAST_IDX);
		stat.hdr_ok     = sync_ok && (pkt_len >= 16'(HDR_LEN)) &&
		                  (pkt_len <= 16'(max_len_q));
		stat.len_is_hdr = (pkt_len == 16'(HDR_LEN));
		stat.body_last  = (body_q == LEN_W'(1));
		stat.out_space  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.store_byte) begin
			hdr_q[idx_q] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			body_q      <= '0;
			max_len_q   <= MAX_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_data;
			end
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.inc_idx) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			// length fits in 12 bits once it passed the check
			if (cmd.load_body) begin
				body_q <= pkt_len[LEN_W-1:0] - LEN_W'(HDR_LEN);
			end else if (cmd.dec_body) begin
				body_q <= body_q - LEN_W'(1);
			end
			if (cmd.emit_hdr || cmd.emit_body) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hdr) begin
			out_q.packet_byte     <= hdr_q[idx_q];
			out_q.first_of_packet <= (idx_q == '0);
			out_q.last_of_packet  <= (idx_q == HDR_LAST_IDX) && (pkt_len == 16'(HDR_LEN));
		end else if (cmd.emit_body) begin
			out_q.packet_byte     <= in_byte;
			out_q.first_of_packet <= 1'b0;
			out_q.last_of_packet  <= (body_q == LEN_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### design/sldf_ctrl.sv
// ----------------------------------------------------------------------------
// sldf_ctrl
// Controller: hunt, header collect, header release and body pass phases.
// ----------------------------------------------------------------------------
module sldf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sldf_pkg::stat_t  stat,
	output sldf_pkg::cmd_t   cmd
);
	import sldf_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   acc;

	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = stat.out_space;
		unique case (state_q)
			ST_HUNT: begin
				if (acc && stat.is_sync) begin
					cmd.store_byte = 1'b1;
					cmd.inc_idx    = 1'b1;
					state_d        = ST_HDR;
				end
			end
			ST_HDR: begin
				if (acc) begin
					cmd.store_byte = 1'b1;
					if (stat.idx_last) begin
						cmd.clr_idx = 1'b1;
						state_d     = stat.hdr_ok ? ST_EMIT : ST_HUNT;
					end else begin
						cmd.inc_idx = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				in_ready = 1'b0;
				if (stat.out_space) begin
					cmd.emit_hdr = 1'b1;
					if (stat.idx_last) begin
						cmd.clr_idx   = 1'b1;
						cmd.load_body = 1'b1;
						state_d       = stat.len_is_hdr ? ST_HUNT : ST_BODY;
					end else begin
						cmd.inc_idx = 1'b1;
					end
				end
			end
			ST_BODY: begin
				if (acc) begin
					cmd.emit_body = 1'b1;
					cmd.dec_body  = 1'b1;
					if (stat.body_last) begin
						state_d = ST_HUNT;
					end
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

endmodule

### design/sync_length_packet_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_packet_deframer
// Finds '#'-synced, length-prefixed packets in a byte stream and forwards them.
// ----------------------------------------------------------------------------
// Channels: stream (sink) takes one received byte per beat; packet (source)
// gives one packet byte per beat with first/last marks; cfg (sink, always
// ready) writes max_packet_length. The user must write it only while the block
// is idle; the block does not enforce it. Bytes are dropped until a '#'
// arrives; that byte and the next six form the header, giving no output. After the
// seventh, a good header (bytes 1..3 '#', little-endian length in bytes 4..5
// between 7 and max_packet_length) is released from the header store at one
// byte per cycle while packet is not stalled, with stream not ready. Body
// bytes pass through the single output register onto packet the cycle after
// they are accepted. A bad header is dropped and hunting resumes. Stream
// takes one byte per cycle while packet is not stalled, except during header
// release. When packet is stalled, the output register holds and stream drops
// ready. Reset clears phase and counters and sets max_packet_length to 2048.
// ----------------------------------------------------------------------------
module sync_length_packet_deframer (
	input logic clk,
	input logic arst_n,
	sldf_chan_if.sink   stream,
	sldf_chan_if.source packet,
	sldf_chan_if.sink   cfg
);
	import sldf_pkg::*;

	cmd_t      cmd;
	stat_t     stat;
	in_item_t  in_item;
	out_item_t out_item;
	logic      in_ready;
	logic      out_valid;

	assign in_item      = stream.data;
	assign stream.ready = in_ready;
	assign cfg.ready    = 1'b1;
	assign packet.valid = out_valid;
	assign packet.data  = out_item;

	sldf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sldf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (in_item.data_byte),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.out_valid (out_valid),
		.out_ready (packet.ready),
		.out_data  (out_item)
	);

endmodule

### design/sldf_chk.sv
// ----------------------------------------------------------------------------
// sldf_chk
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sldf_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_first,
	input logic       out_last
);
	import sldf_pkg::*;

	// stalled beat must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(out_first) && $stable(out_last))
		else $error("output beat changed while stalled");

	// no input while the output register is blocked
	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input ready while output stalled");

	// a packet starts on the sync byte
	a_first_sync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_first |-> out_byte == SYNC_BYTE && !out_last)
		else $error("bad first beat");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid in reset");

endmodule

bind sync_length_packet_deframer sldf_chk u_sldf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (stream.valid),
	.in_ready  (stream.ready),
	.out_valid (packet.valid),
	.out_ready (packet.ready),
	.out_byte  (packet.data.packet_byte),
	.out_first (packet.data.first_of_packet),
	.out_last  (packet.data.last_of_packet)
);

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sync/length packet deframer. A byte-level
// predictor tracks hunt/header/body state and queues the packet beats each
// stream beat should produce; every packet beat is checked against it.
// Directed frames hit the header checks and length limits, then random
// traffic runs under three flow-control mixes.
// ----------------------------------------------------------------------------
module testbench;
	import sldf_pkg::*;

	typedef enum logic [1:0] {
		HUNTING,
		IN_HEADER,
		IN_BODY
	} deframe_state_t;

	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_FRAME_BYTES = 100;

	logic clk;
	logic arst_n;

	sldf_chan_if #(.payload_t(in_item_t))  stream_ch ();
	sldf_chan_if #(.payload_t(out_item_t)) packet_ch ();
	sldf_chan_if #(.payload_t(cfg_item_t)) cfg_ch ();

	sync_length_packet_deframer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.packet (packet_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	deframe_state_t   deframe_state;
	logic [7:0]       hdr_bytes [0:5];
	int               hdr_count;
	logic [LEN_W-1:0] body_left;
	logic [LEN_W-1:0] max_len;
	out_item_t        expected_beats [$];

	int src_gap_pct;
	int sink_stall_pct;
	int errors;
	int stream_bytes;
	int frame_bytes;
	int headers_dropped;
	int beats_checked;
	int packets_checked;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		packet_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (packet_ch.valid && packet_ch.ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected packet beat %h first=%b last=%b", $realtime,
					packet_ch.data.packet_byte, packet_ch.data.first_of_packet,
					packet_ch.data.last_of_packet);
				errors++;
			end else begin
				if (packet_ch.data != expected_beats[0]) begin
					$display("%0t: beat mismatch: expected %h/%b/%b, got %h/%b/%b", $realtime,
						expected_beats[0].packet_byte, expected_beats[0].first_of_packet,
						expected_beats[0].last_of_packet, packet_ch.data.packet_byte,
						packet_ch.data.first_of_packet, packet_ch.data.last_of_packet);
					errors++;
				end
				if (packet_ch.data.last_of_packet)
					packets_checked++;
				beats_checked++;
				void'(expected_beats.pop_front());
			end
		end
	end

	task automatic push_beat(input logic [7:0] b, input logic first, input logic last);
		out_item_t item;
		item.packet_byte = b;
		item.first_of_packet = first;
		item.last_of_packet = last;
		expected_beats.push_back(item);
	endtask

	task automatic predict_byte(input logic [7:0] b);
		logic [15:0] len;
		logic        sync_ok;
		case (deframe_state)
			IN_HEADER: begin
				if (hdr_count < 6) begin
					hdr_bytes[hdr_count] = b;
					hdr_count++;
				end else begin
					sync_ok = hdr_bytes[1] == SYNC_BYTE && hdr_bytes[2] == SYNC_BYTE &&
						hdr_bytes[3] == SYNC_BYTE;
					len = {hdr_bytes[5], hdr_bytes[4]};
					if (!sync_ok || len > max_len || len < HDR_LEN) begin
						headers_dropped++;
						deframe_state = HUNTING;
					end else begin
						for (int k = 0; k < 6; k++)
							push_beat(hdr_bytes[k], k == 0, 1'b0);
						push_beat(b, 1'b0, len == HDR_LEN);
						if (len == HDR_LEN) begin
							deframe_state = HUNTING;
						end else begin
							body_left = LEN_W'(len - HDR_LEN);
							deframe_state = IN_BODY;
						end
					end
					hdr_count = 0;
				end
			end
			IN_BODY: begin
				body_left = body_left - LEN_W'(1);
				push_beat(b, 1'b0, body_left == 0);
				if (body_left == 0)
					deframe_state = HUNTING;
			end
			default: begin
				if (b == SYNC_BYTE) begin
					hdr_bytes[0] = b;
					hdr_count = 1;
					deframe_state = IN_HEADER;
				end
			end
		endcase
	endtask

	// entered and left at a falling edge; valid stays up for a following beat
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_gap_pct) begin
			stream_ch.valid <= 1'b0;
			@(negedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.data.data_byte <= b;
		@(posedge clk);
		while (!stream_ch.ready)
			@(posedge clk);
		predict_byte(b);
		stream_bytes++;
		@(negedge clk);
	endtask

	task automatic drain;
		stream_ch.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_len(input logic [LEN_W-1:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		max_len = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// bad_pos 1..3 replaces that sync byte with bad_val; 0 keeps the header well formed
	task automatic send_header(input logic [15:0] len, input int bad_pos,
			input logic [7:0] bad_val, input logic [7:0] byte6);
		send_byte(SYNC_BYTE);
		for (int k = 1; k <= 3; k++)
			send_byte(k == bad_pos ? bad_val : SYNC_BYTE);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		send_byte(byte6);
		frame_bytes += HDR_LEN;
	endtask

	task automatic send_frame(input logic [15:0] len, input int bad_pos,
			input logic [7:0] bad_val);
		send_header(len, bad_pos, bad_val, 8'($urandom_range(255)));
		if (bad_pos == 0 && len >= HDR_LEN && len <= max_len) begin
			repeat (int'(len) - HDR_LEN) begin
				send_byte(8'($urandom_range(255)));
				frame_bytes++;
			end
		end
	endtask

	task automatic test_basic_frames;
		send_byte(8'h00);
		send_byte(8'hFF);
		// header-only packet: last mark on header byte 6
		send_header(16'd7, 0, 8'h00, 8'hFF);
		send_header(16'd9, 0, 8'h00, 8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_header(16'd6, 0, 8'h00, 8'h5A);
		drain();
	endtask

	task automatic test_bad_sync;
		send_header(16'd8, 2, 8'h22, 8'h11);
		send_header(16'd8, 1, 8'hA3, 8'h11);
		drain();
	endtask

	task automatic test_length_limits;
		write_max_len(12'd0);
		send_header(16'd7, 0, 8'h00, 8'h33);
		write_max_len(12'd7);
		send_header(16'd7, 0, 8'h00, 8'h44);
		send_header(16'd8, 0, 8'h00, 8'h55);
		write_max_len(12'd4095);
		send_header(16'd4096, 0, 8'h00, 8'h66);
		send_header(16'hFFFF, 0, 8'h00, 8'h77);
		drain();
	endtask

	task automatic run_random_traffic(input int gap_pct, input int stall_pct,
			input logic [LEN_W-1:0] limit);
		int          start;
		int          r;
		logic [15:0] len;
		int          bad_pos;
		logic [7:0]  bad_val;
		src_gap_pct = gap_pct;
		sink_stall_pct = stall_pct;
		write_max_len(limit);
		start = frame_bytes;
		while (frame_bytes - start < RANDOM_FRAME_BYTES) begin
			if ($urandom_range(99) < 20)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
			r = $urandom_range(99);
			if (r < 65)
				len = 16'($urandom_range(7, 24));
			else if (r < 68)
				len = 16'($urandom_range(25, 4095));
			else if (r < 76)
				len = 16'($urandom_range(0, 6));
			else if (r < 83)
				len = 16'(max_len) + 16'd1;
			else if (r < 90)
				len = (max_len < HDR_LEN) ? 16'(HDR_LEN) : 16'(max_len);
			else
				len = 16'($urandom_range(65535));
			// accepted bodies stay short so the run keeps to its byte budget
			if (len > 64 && len <= max_len)
				len = 16'($urandom_range(7, 64));
			bad_pos = ($urandom_range(99) < 12) ? $urandom_range(1, 3) : 0;
			bad_val = 8'($urandom_range(255));
			if (bad_val == SYNC_BYTE)
				bad_val = bad_val ^ 8'h01;
			send_frame(len, bad_pos, bad_val);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		stream_ch.valid = 1'b0;
		stream_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		deframe_state = HUNTING;
		hdr_count = 0;
		body_left = '0;
		max_len = MAX_LEN_RESET;
		src_gap_pct = 9;
		sink_stall_pct = 50;
		errors = 0;
		stream_bytes = 0;
		frame_bytes = 0;
		headers_dropped = 0;
		beats_checked = 0;
		packets_checked = 0;
		clk = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_frames();
		test_bad_sync();
		test_length_limits();
		run_random_traffic(9, 50, 12'd16);
		run_random_traffic(50, 9, 12'd4095);
		run_random_traffic(0, 0, 12'($urandom_range(7, 60)));

		if (expected_beats.size() != 0) begin
			$display("%0t: %0d packet beats never arrived", $realtime, expected_beats.size());
			errors++;
		end
		$display("Sent %0d stream bytes (%0d in frames) over three flow-control mixes,",
			stream_bytes, frame_bytes);
		$display("checked %0d beats in %0d packets; %0d headers rejected, %0d errors",
			beats_checked, packets_checked, headers_dropped, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d beats outstanding", $realtime, expected_beats.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
